// ===== hdl/rv32id_pkg.sv =====
// ----------------------------------------------------------------------------
// rv32id_pkg
// Shared types and constants for the RV32I instruction decoder.
// ----------------------------------------------------------------------------
package rv32id_pkg;

    // Major opcodes (full 7-bit field)
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    // funct7 of SUB / SRA / SRAI
    localparam logic [6:0] FUNCT7_ALT = 7'h20;
    localparam logic [6:0] FUNCT7_STD = 7'h00;

    // funct12 of ECALL / EBREAK
    localparam logic [11:0] FUNCT12_ECALL  = 12'h000;
    localparam logic [11:0] FUNCT12_EBREAK = 12'h001;

    typedef enum logic [3:0] {
        ST_OK     = 4'd0,
        ST_LOAD   = 4'd1,
        ST_FENCE  = 4'd2,
        ST_OPIMM  = 4'd3,
        ST_STORE  = 4'd4,
        ST_OP     = 4'd5,
        ST_BRANCH = 4'd6,
        ST_JALR   = 4'd7,
        ST_SYSTEM = 4'd8,
        ST_BADOP  = 4'd9
    } status_t;

    typedef enum logic [5:0] {
        ID_LUI    = 6'd0,
        ID_AUIPC  = 6'd1,
        ID_JAL    = 6'd2,
        ID_JALR   = 6'd3,
        ID_BEQ    = 6'd4,
        ID_BNE    = 6'd5,
        ID_BLT    = 6'd6,
        ID_BGE    = 6'd7,
        ID_BLTU   = 6'd8,
        ID_BGEU   = 6'd9,
        ID_LB     = 6'd10,
        ID_LH     = 6'd11,
        ID_LW     = 6'd12,
        ID_LBU    = 6'd13,
        ID_LHU    = 6'd14,
        ID_SB     = 6'd15,
        ID_SH     = 6'd16,
        ID_SW     = 6'd17,
        ID_ADDI   = 6'd18,
        ID_SLTI   = 6'd19,
        ID_SLTIU  = 6'd20,
        ID_XORI   = 6'd21,
        ID_ORI    = 6'd22,
        ID_ANDI   = 6'd23,
        ID_SLLI   = 6'd24,
        ID_SRLI   = 6'd25,
        ID_SRAI   = 6'd26,
        ID_ADD    = 6'd27,
        ID_SUB    = 6'd28,
        ID_SLL    = 6'd29,
        ID_SLT    = 6'd30,
        ID_SLTU   = 6'd31,
        ID_XOR    = 6'd32,
        ID_SRL    = 6'd33,
        ID_SRA    = 6'd34,
        ID_OR     = 6'd35,
        ID_AND    = 6'd36,
        ID_FENCE  = 6'd37,
        ID_FENCEI = 6'd38,
        ID_ECALL  = 6'd39,
        ID_EBREAK = 6'd40,
        ID_CSRRW  = 6'd41,
        ID_CSRRS  = 6'd42,
        ID_CSRRC  = 6'd43,
        ID_CSRRWI = 6'd44,
        ID_CSRRSI = 6'd45,
        ID_CSRRCI = 6'd46
    } op_id_t;

    // One decoded item
    typedef struct packed {
        status_t            status;
        op_id_t             op_id;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic signed [31:0] immediate;
    } dec_t;

    // Packed width of a decoded item on the output bus, and the bus width
    localparam int DEC_BITS  = 57;
    localparam int OUT_BYTES = (DEC_BITS + 7) / 8;
    localparam int OUT_BITS  = OUT_BYTES * 8;

endpackage

// ===== hdl/rv32id_decode.sv =====
// ----------------------------------------------------------------------------
// rv32id_decode
// Combinational RV32I field extraction, instruction lookup and error check.
// ----------------------------------------------------------------------------
module rv32id_decode
(
    input  logic [31:0]      word,
    output rv32id_pkg::dec_t dec
);

    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  r1;
    logic [4:0]  r2;
    logic [6:0]  f7;
    logic [11:0] f12;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] imm_u;
    rv32id_pkg::dec_t raw;

    assign opc   = word[6:0];
    assign rd    = word[11:7];
    assign f3    = word[14:12];
    assign r1    = word[19:15];
    assign r2    = word[24:20];
    assign f7    = word[31:25];
    assign f12   = word[31:20];
    assign imm_i = {{20{word[31]}}, word[31:20]};
    assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
    assign imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
    assign imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
    assign imm_u = {word[31:12], 12'h000};

    always_comb
    begin
        raw           = '0;
        raw.status    = rv32id_pkg::ST_OK;
        raw.op_id     = rv32id_pkg::ID_LUI;
        case (opc)
            rv32id_pkg::OPC_LUI:
            begin
                raw.op_id     = rv32id_pkg::ID_LUI;
                raw.dest_reg  = rd;
                raw.immediate = imm_u;
            end
            rv32id_pkg::OPC_AUIPC:
            begin
                raw.op_id     = rv32id_pkg::ID_AUIPC;
                raw.dest_reg  = rd;
                raw.immediate = imm_u;
            end
            rv32id_pkg::OPC_JAL:
            begin
                raw.op_id     = rv32id_pkg::ID_JAL;
                raw.dest_reg  = rd;
                raw.immediate = imm_j;
            end
            rv32id_pkg::OPC_JALR:
            begin
                raw.op_id     = rv32id_pkg::ID_JALR;
                raw.dest_reg  = rd;
                raw.src1_reg  = r1;
                raw.immediate = imm_i;
                if (f3 != 3'd0)
                    raw.status = rv32id_pkg::ST_JALR;
            end
            rv32id_pkg::OPC_BRANCH:
            begin
                raw.src1_reg  = r1;
                raw.src2_reg  = r2;
                raw.immediate = imm_b;
                case (f3)
                    3'd0:    raw.op_id = rv32id_pkg::ID_BEQ;
                    3'd1:    raw.op_id = rv32id_pkg::ID_BNE;
                    3'd4:    raw.op_id = rv32id_pkg::ID_BLT;
                    3'd5:    raw.op_id = rv32id_pkg::ID_BGE;
                    3'd6:    raw.op_id = rv32id_pkg::ID_BLTU;
                    3'd7:    raw.op_id = rv32id_pkg::ID_BGEU;
                    default: raw.status = rv32id_pkg::ST_BRANCH;
                endcase
            end
            rv32id_pkg::OPC_LOAD:
            begin
                raw.dest_reg  = rd;
                raw.src1_reg  = r1;
                raw.immediate = imm_i;
                case (f3)
                    3'd0:    raw.op_id = rv32id_pkg::ID_LB;
                    3'd1:    raw.op_id = rv32id_pkg::ID_LH;
                    3'd2:    raw.op_id = rv32id_pkg::ID_LW;
                    3'd4:    raw.op_id = rv32id_pkg::ID_LBU;
                    3'd5:    raw.op_id = rv32id_pkg::ID_LHU;
                    default: raw.status = rv32id_pkg::ST_LOAD;
                endcase
            end
            rv32id_pkg::OPC_STORE:
            begin
                raw.src1_reg  = r1;
                raw.src2_reg  = r2;
                raw.immediate = imm_s;
                case (f3)
                    3'd0:    raw.op_id = rv32id_pkg::ID_SB;
                    3'd1:    raw.op_id = rv32id_pkg::ID_SH;
                    3'd2:    raw.op_id = rv32id_pkg::ID_SW;
                    default: raw.status = rv32id_pkg::ST_STORE;
                endcase
            end
            rv32id_pkg::OPC_OPIMM:
            begin
                raw.dest_reg  = rd;
                raw.src1_reg  = r1;
                raw.immediate = imm_i;
                case (f3)
                    3'd0:    raw.op_id = rv32id_pkg::ID_ADDI;
                    3'd2:    raw.op_id = rv32id_pkg::ID_SLTI;
                    3'd3:    raw.op_id = rv32id_pkg::ID_SLTIU;
                    3'd4:    raw.op_id = rv32id_pkg::ID_XORI;
                    3'd6:    raw.op_id = rv32id_pkg::ID_ORI;
                    3'd7:    raw.op_id = rv32id_pkg::ID_ANDI;
                    3'd1:
                    begin
                        // shift amount replaces the immediate
                        raw.op_id     = rv32id_pkg::ID_SLLI;
                        raw.immediate = {27'd0, r2};
                        if (f7 != rv32id_pkg::FUNCT7_STD)
                            raw.status = rv32id_pkg::ST_OPIMM;
                    end
                    default:
                    begin
                        raw.immediate = {27'd0, r2};
                        if (f7 == rv32id_pkg::FUNCT7_STD)
                            raw.op_id = rv32id_pkg::ID_SRLI;
                        else if (f7 == rv32id_pkg::FUNCT7_ALT)
                            raw.op_id = rv32id_pkg::ID_SRAI;
                        else
                            raw.status = rv32id_pkg::ST_OPIMM;
                    end
                endcase
            end
            rv32id_pkg::OPC_OP:
            begin
                raw.dest_reg = rd;
                raw.src1_reg = r1;
                raw.src2_reg = r2;
                if (f7 == rv32id_pkg::FUNCT7_STD)
                begin
                    case (f3)
                        3'd0:    raw.op_id = rv32id_pkg::ID_ADD;
                        3'd1:    raw.op_id = rv32id_pkg::ID_SLL;
                        3'd2:    raw.op_id = rv32id_pkg::ID_SLT;
                        3'd3:    raw.op_id = rv32id_pkg::ID_SLTU;
                        3'd4:    raw.op_id = rv32id_pkg::ID_XOR;
                        3'd5:    raw.op_id = rv32id_pkg::ID_SRL;
                        3'd6:    raw.op_id = rv32id_pkg::ID_OR;
                        default: raw.op_id = rv32id_pkg::ID_AND;
                    endcase
                end
                else if (f7 == rv32id_pkg::FUNCT7_ALT && f3 == 3'd0)
                    raw.op_id = rv32id_pkg::ID_SUB;
                else if (f7 == rv32id_pkg::FUNCT7_ALT && f3 == 3'd5)
                    raw.op_id = rv32id_pkg::ID_SRA;
                else
                    raw.status = rv32id_pkg::ST_OP;
            end
            rv32id_pkg::OPC_FENCE:
            begin
                case (f3)
                    3'd0:
                    begin
                        // pred and succ only
                        raw.op_id     = rv32id_pkg::ID_FENCE;
                        raw.immediate = {24'd0, word[27:20]};
                    end
                    3'd1:    raw.op_id = rv32id_pkg::ID_FENCEI;
                    default: raw.status = rv32id_pkg::ST_FENCE;
                endcase
            end
            rv32id_pkg::OPC_SYSTEM:
            begin
                raw.dest_reg  = rd;
                raw.src1_reg  = r1;
                raw.immediate = {20'd0, f12};
                case (f3)
                    3'd0:
                    begin
                        raw.dest_reg  = 5'd0;
                        raw.src1_reg  = 5'd0;
                        raw.immediate = '0;
                        if (rd != 5'd0 || r1 != 5'd0)
                            raw.status = rv32id_pkg::ST_SYSTEM;
                        else if (f12 == rv32id_pkg::FUNCT12_ECALL)
                            raw.op_id = rv32id_pkg::ID_ECALL;
                        else if (f12 == rv32id_pkg::FUNCT12_EBREAK)
                            raw.op_id = rv32id_pkg::ID_EBREAK;
                        else
                            raw.status = rv32id_pkg::ST_SYSTEM;
                    end
                    3'd1:    raw.op_id = rv32id_pkg::ID_CSRRW;
                    3'd2:    raw.op_id = rv32id_pkg::ID_CSRRS;
                    3'd3:    raw.op_id = rv32id_pkg::ID_CSRRC;
                    3'd5:    raw.op_id = rv32id_pkg::ID_CSRRWI;
                    3'd6:    raw.op_id = rv32id_pkg::ID_CSRRSI;
                    3'd7:    raw.op_id = rv32id_pkg::ID_CSRRCI;
                    default: raw.status = rv32id_pkg::ST_SYSTEM;
                endcase
            end
            default: raw.status = rv32id_pkg::ST_BADOP;
        endcase
    end

    // Any error clears the whole payload
    always_comb
    begin
        dec = raw;
        if (raw.status != rv32id_pkg::ST_OK)
        begin
            dec        = '0;
            dec.status = raw.status;
        end
    end

endmodule

// ===== hdl/rv32i_instruction_decoder.sv =====
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder
// Streaming RV32I decoder: one instruction word in, one decoded item out.
// ----------------------------------------------------------------------------
// Path: an accepted word passes the input register, the decode logic and the
//   result register, which presents the decoded item on the output bus.
// Throughput: 1 item per cycle; both stages advance together whenever the
//   result register is empty or being drained.
// Reset: rst_n clears both stage valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
module rv32i_instruction_decoder
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] instr_word
    input  logic [31:0]                     s_axis_tdata,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [3:0] status, [9:4] op_id, [14:10] dest_reg, [19:15] src1_reg,
    // [24:20] src2_reg, [56:25] immediate, [63:57] zero
    output logic [rv32id_pkg::OUT_BITS-1:0] m_axis_tdata
);

    // Input stage: holds the raw instruction word
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [31:0] in_word_reg;

    // Result stage: holds the decoded item
    logic              out_valid_reg;
    logic              out_valid_next;
    rv32id_pkg::dec_t  out_dec_reg;
    rv32id_pkg::dec_t  dec;

    logic out_ready;
    logic in_ready;
    logic in_take;
    logic out_load;

    // Result register frees up when empty or drained this cycle; the input
    // stage advances into it under the same condition.
    assign out_ready = !out_valid_reg || m_axis_tready;
    assign in_ready  = !in_valid_reg || out_ready;
    assign in_take   = s_axis_tvalid && in_ready;
    assign out_load  = in_valid_reg && out_ready;

    assign s_axis_tready = in_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
            in_valid_next = s_axis_tvalid;

        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the word on acceptance
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_word_reg <= s_axis_tdata;
    end

    rv32id_decode u_decode
    (
        .word (in_word_reg),
        .dec  (dec)
    );

    // Load the decoded item when the input stage advances
    always_ff @(posedge clk)
    begin
        if (out_load)
            out_dec_reg <= dec;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        {(rv32id_pkg::OUT_BITS - rv32id_pkg::DEC_BITS){1'b0}},
        out_dec_reg.immediate,
        out_dec_reg.src2_reg,
        out_dec_reg.src1_reg,
        out_dec_reg.dest_reg,
        out_dec_reg.op_id,
        out_dec_reg.status
    };

    // An accepted word always lands in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> in_valid_reg)
        else $error("accepted item not held in input stage");

    // A word in the input stage moves on when the result side can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_ready |=> out_valid_reg)
        else $error("input stage did not advance");

    // Error results carry an all-zero payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_dec_reg.status != rv32id_pkg::ST_OK
        |-> out_dec_reg.op_id == rv32id_pkg::ID_LUI && out_dec_reg.dest_reg == 5'd0
            && out_dec_reg.src1_reg == 5'd0 && out_dec_reg.src2_reg == 5'd0
            && out_dec_reg.immediate == 32'sd0)
        else $error("error result with nonzero payload");

    // A stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_dec_reg))
        else $error("stalled result changed");

endmodule
